// ===== design/pmu_pkg.sv =====
`default_nettype none
package pmu_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_STEPS_MAX = 24;
    localparam int AGE_STEPS        = 16;
    localparam int SQRT_STEPS       = 26;
    localparam int DIV_STEPS        = 18;

    localparam logic [2:0] MODE_BURST   = 3'd0;
    localparam logic [2:0] MODE_ORBIT   = 3'd1;
    localparam logic [2:0] MODE_SPIRAL  = 3'd2;
    localparam logic [2:0] MODE_ATTRACT = 3'd3;
    localparam logic [2:0] MODE_RAIN    = 3'd4;
    localparam logic [2:0] MODE_WANDER  = 3'd5;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_CENTER_X = 3'd1;
    localparam logic [2:0] REG_CENTER_Y = 3'd2;
    localparam logic [2:0] REG_SPRITE_W = 3'd3;
    localparam logic [2:0] REG_SPRITE_H = 3'd4;
    localparam logic [2:0] REG_FULL     = 3'd5;

    localparam logic [23:0] FULL_LIFE_RST = 24'd65536;
    localparam logic signed [19:0] CORDIC_X0 = 20'sd39797;  // 1/gain in Q.16
    localparam logic [16:0] RAIN_ACCEL   = 17'd56320;       // 220 px/s^2
    localparam logic [26:0] WANDER_SPEED = 27'd20480;       // 80 px/s
    localparam logic [16:0] STR_BASE     = 17'd12800;       // 50 px/s
    localparam logic [33:0] STR_SPAN     = 34'd89600;       // 350 px/s
    localparam logic [23:0] DELAY_BASE   = 24'd6554;        // 0.1 s
    localparam logic [49:0] NEAR_LIMIT   = 50'd65536;       // 1 px^2

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS_MAX] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic [23:0]        sw;
        logic [23:0]        sh;
        logic [23:0]        full;
    } t_cfg;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] speed_x;
        logic signed [23:0] speed_y;
        logic [23:0]        life_left;
        logic [15:0]        phase;
        logic signed [19:0] spin_rate;
        logic [23:0]        ring_radius;
        logic [23:0]        turn_delay;
        logic [15:0]        step_time;
        logic [15:0]        rand_heading;
        logic [15:0]        rand_fraction;
    } t_in;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic [23:0]        life;
        logic               alive;
        logic [15:0]        phase;
        logic [23:0]        delay;
        logic [15:0]        dt;
        logic [23:0]        radius;
        logic [15:0]        heading;
        logic               wexp;
        logic signed [36:0] spin_p;
        logic [31:0]        rain_p;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic [48:0]        sqx;
        logic [48:0]        sqy;
        logic               near;
        logic [50:0]        srem;
        logic [50:0]        slen;
        logic [23:0]        arem;
        logic [15:0]        age;
        logic [25:0]        r;
        logic [16:0]        str;
        logic               flip;
        logic signed [19:0] cox;
        logic signed [19:0] coy;
        logic signed [33:0] coz;
        logic signed [46:0] mx;
        logic signed [46:0] my;
        logic [25:0]        len;
        logic signed [42:0] nx;
        logic signed [42:0] ny;
        logic [43:0]        dremx;
        logic [43:0]        dremy;
        logic [17:0]        qx;
        logic [17:0]        qy;
        logic signed [40:0] mvx;
        logic signed [40:0] mvy;
    } t_item;

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        logic signed [23:0] res;
        if (v > 48'sd8388607) begin
            res = 24'sh7FFFFF;
        end else if (v < -48'sd8388608) begin
            res = 24'sh800000;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== design/particle_motion_update.sv =====
// Throughput: one item per cycle unless the output stalls; every stage holds one item and the whole pipe
// advances together, so a stalled output freezes all stages without loss.
// Depth is set by the age divider (16), the CORDIC rotator, the attract square root (26)
// and the attract divider (18). Reset (synchronous, active low) clears the valid
// bits and returns the registers to burst mode, centered at 0, full_life = 1.0 s.
`default_nettype none
module particle_motion_update import pmu_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,

    // particle in
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic signed [23:0] i_pos_x,
    input  wire logic signed [23:0] i_pos_y,
    input  wire logic signed [23:0] i_speed_x,
    input  wire logic signed [23:0] i_speed_y,
    input  wire logic [23:0] i_life_left,
    input  wire logic [15:0] i_phase,
    input  wire logic signed [19:0] i_spin_rate,
    input  wire logic [23:0] i_ring_radius,
    input  wire logic [23:0] i_turn_delay,
    input  wire logic [15:0] i_step_time,
    input  wire logic [15:0] i_rand_heading,
    input  wire logic [15:0] i_rand_fraction,

    // particle out
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic signed [23:0] o_new_pos_x,
    output logic signed [23:0] o_new_pos_y,
    output logic signed [23:0] o_new_speed_x,
    output logic signed [23:0] o_new_speed_y,
    output logic [23:0]      o_new_life_left,
    output logic [15:0]      o_new_phase,
    output logic [23:0]      o_new_turn_delay,
    output logic             o_alive
);

    t_cfg  r_cfg;
    t_in   w_in;
    logic  w_en;
    logic  w_wr;
    logic [2:0] w_idx;

    logic  w_vld_f, w_vld_a, w_vld_c, w_vld_t, w_vld_b;
    t_item w_item_f, w_item_a, w_item_c, w_item_t, w_item_b;

    // ---------------- register port ----------------
    // The user must change registers only while no item is in flight; the block itself does
    // not enforce this. Every stage reads them directly instead of carrying a copy.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= MODE_BURST;
            r_cfg.cx   <= '0;
            r_cfg.cy   <= '0;
            r_cfg.sw   <= '0;
            r_cfg.sh   <= '0;
            r_cfg.full <= FULL_LIFE_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MODE:     r_cfg.mode <= pwdata[2:0];
                REG_CENTER_X: r_cfg.cx   <= pwdata[23:0];
                REG_CENTER_Y: r_cfg.cy   <= pwdata[23:0];
                REG_SPRITE_W: r_cfg.sw   <= pwdata[23:0];
                REG_SPRITE_H: r_cfg.sh   <= pwdata[23:0];
                REG_FULL:     r_cfg.full <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MODE:     prdata = 32'(r_cfg.mode);
            REG_CENTER_X: prdata = 32'(r_cfg.cx);
            REG_CENTER_Y: prdata = 32'(r_cfg.cy);
            REG_SPRITE_W: prdata = 32'(r_cfg.sw);
            REG_SPRITE_H: prdata = 32'(r_cfg.sh);
            REG_FULL:     prdata = 32'(r_cfg.full);
            default:      prdata = '0;
        endcase
    end

    // ---------------- pipeline ----------------
    // The last stage is the output register; the whole pipe moves whenever that
    // register is empty or its item is being taken.
    assign w_en       = !w_vld_b || i_out_ready;
    assign o_in_ready = w_en;

    always_comb begin
        w_in.pos_x         = i_pos_x;
        w_in.pos_y         = i_pos_y;
        w_in.speed_x       = i_speed_x;
        w_in.speed_y       = i_speed_y;
        w_in.life_left     = i_life_left;
        w_in.phase         = i_phase;
        w_in.spin_rate     = i_spin_rate;
        w_in.ring_radius   = i_ring_radius;
        w_in.turn_delay    = i_turn_delay;
        w_in.step_time     = i_step_time;
        w_in.rand_heading  = i_rand_heading;
        w_in.rand_fraction = i_rand_fraction;
    end

    // life cut, phase/rain update, squared distance: 3 stages
    pmu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in_valid),
        .i_in    (w_in),
        .i_cfg   (r_cfg),
        .o_vld   (w_vld_f),
        .o_item  (w_item_f)
    );

    // age fraction divider, spiral radius, strength, CORDIC seed: 17 stages
    pmu_age u_age (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld_f),
        .i_item  (w_item_f),
        .i_cfg   (r_cfg),
        .o_vld   (w_vld_a),
        .o_item  (w_item_a)
    );

    // sin/cos, orbit placement, wander heading: CORDIC_STEPS + 2 stages
    pmu_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld_a),
        .i_item  (w_item_a),
        .i_cfg   (r_cfg),
        .o_vld   (w_vld_c),
        .o_item  (w_item_c)
    );

    // distance root and normalized pull speed: 47 stages
    pmu_attract u_attract (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld_c),
        .i_item  (w_item_c),
        .i_cfg   (r_cfg),
        .o_vld   (w_vld_t),
        .o_item  (w_item_t)
    );

    // position integration and output register: 2 stages
    pmu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld_t),
        .i_item  (w_item_t),
        .i_cfg   (r_cfg),
        .o_vld   (w_vld_b),
        .o_item  (w_item_b)
    );

    assign o_out_valid      = w_vld_b;
    assign o_new_pos_x      = w_item_b.px;
    assign o_new_pos_y      = w_item_b.py;
    assign o_new_speed_x    = w_item_b.vx;
    assign o_new_speed_y    = w_item_b.vy;
    assign o_new_life_left  = w_item_b.life;
    assign o_new_phase      = w_item_b.phase;
    assign o_new_turn_delay = w_item_b.delay;
    assign o_alive          = w_item_b.alive;

endmodule
`default_nettype wire

// ===== design/pmu_front.sv =====
`default_nettype none
module pmu_front import pmu_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_in   i_in,
    input  wire t_cfg  i_cfg,
    output logic       o_vld,
    output t_item      o_item
);

    t_item r_s0, r_s1, r_s2;
    t_item n_s0, n_s1, n_s2;
    logic [2:0] r_vld;

    // stage 0: life cut, wander timer, raw products
    always_comb begin
        logic dead;
        logic wexp;
        n_s0 = '0;
        dead = (i_in.life_left <= {8'd0, i_in.step_time});
        wexp = (i_in.turn_delay <= {8'd0, i_in.step_time});
        n_s0.px      = i_in.pos_x;
        n_s0.py      = i_in.pos_y;
        n_s0.vx      = i_in.speed_x;
        n_s0.vy      = i_in.speed_y;
        n_s0.phase   = i_in.phase;
        n_s0.radius  = i_in.ring_radius;
        n_s0.heading = i_in.rand_heading;
        n_s0.dt      = i_in.step_time;
        n_s0.alive   = !dead;
        n_s0.life    = dead ? '0 : i_in.life_left - {8'd0, i_in.step_time};
        n_s0.wexp    = wexp;
        n_s0.delay   = i_in.turn_delay;
        if (!dead && i_cfg.mode == MODE_WANDER) begin
            n_s0.delay = wexp ? DELAY_BASE + {10'd0, i_in.rand_fraction[15:2]}
                              : i_in.turn_delay - {8'd0, i_in.step_time};
        end
        n_s0.spin_p = i_in.spin_rate * $signed({1'b0, i_in.step_time});
        n_s0.rain_p = 32'(RAIN_ACCEL) * 32'(i_in.step_time);
        n_s0.dx = {i_cfg.cx[23], i_cfg.cx} - {i_in.pos_x[23], i_in.pos_x};
        n_s0.dy = {i_cfg.cy[23], i_cfg.cy} - {i_in.pos_y[23], i_in.pos_y};
    end

    // stage 1: phase advance, rain gravity, squares, age numerator
    always_comb begin
        logic signed [36:0] spin_r;
        logic [32:0]        rain_r;
        logic signed [47:0] vy_sum;
        logic signed [49:0] sqx_f;
        logic signed [49:0] sqy_f;
        n_s1   = r_s0;
        spin_r = r_s0.spin_p + 37'sd32768;
        rain_r = {1'b0, r_s0.rain_p} + 33'd32768;
        vy_sum = 48'(r_s0.vy) + 48'(signed'({1'b0, rain_r[32:16]}));
        sqx_f  = r_s0.dx * r_s0.dx;
        sqy_f  = r_s0.dy * r_s0.dy;
        if (r_s0.alive && (i_cfg.mode == MODE_ORBIT || i_cfg.mode == MODE_SPIRAL)) begin
            n_s1.phase = r_s0.phase + spin_r[31:16];
        end
        if (r_s0.alive && i_cfg.mode == MODE_RAIN) begin
            n_s1.vy = sat24(vy_sum);
        end
        n_s1.sqx  = sqx_f[48:0];
        n_s1.sqy  = sqy_f[48:0];
        n_s1.arem = (r_s0.life < i_cfg.full) ? i_cfg.full - r_s0.life : '0;
        n_s1.age  = '0;
    end

    // stage 2: squared distance, sqrt seed
    always_comb begin
        logic [49:0] sum;
        n_s2      = r_s1;
        sum       = {1'b0, r_s1.sqx} + {1'b0, r_s1.sqy};
        n_s2.near = (sum <= NEAR_LIMIT);
        n_s2.srem = {1'b0, sum};
        n_s2.slen = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    assign o_vld  = r_vld[2];
    assign o_item = r_s2;

endmodule
`default_nettype wire

// ===== design/pmu_age.sv =====
`default_nettype none
module pmu_age import pmu_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output logic       o_vld,
    output t_item      o_item
);

    localparam int DEPTH = AGE_STEPS + 1;

    t_item r_stg [DEPTH];
    logic [DEPTH-1:0] r_vld;

    for (genvar k = 0; k < DEPTH; k++) begin : g_stg
        t_item w_src;
        t_item n_stg;
        if (k == 0) begin : g_first
            assign w_src = i_item;
        end else begin : g_next
            assign w_src = r_stg[k-1];
        end

        if (k < AGE_STEPS) begin : g_div
            // one quotient bit of age = num * 2^16 / full_life
            always_comb begin
                logic [24:0] rem2;
                logic        ge;
                n_stg = w_src;
                rem2  = {w_src.arem, 1'b0};
                ge    = (rem2 >= {1'b0, i_cfg.full});
                n_stg.arem = ge ? 24'(rem2 - {1'b0, i_cfg.full}) : rem2[23:0];
                n_stg.age  = {w_src.age[14:0], ge};
            end
        end else begin : g_use
            // spiral radius, attract strength, CORDIC seed
            always_comb begin
                logic [15:0] agev;
                logic [18:0] t5;
                logic [17:0] kmul;
                logic [42:0] rp;
                logic [33:0] sp;
                logic [15:0] ang;
                logic [15:0] a;
                n_stg = w_src;
                agev  = (i_cfg.full == '0) ? '0 : w_src.age;
                t5    = 19'(agev) * 19'd5;
                kmul  = 18'(t5 >> 1) + 18'd65536;
                rp    = 43'(w_src.radius) * 43'(kmul) + 43'd32768;
                sp    = 34'(agev) * STR_SPAN + 34'd32768;
                n_stg.r   = (i_cfg.mode == MODE_SPIRAL) ? rp[41:16] : {2'b00, w_src.radius};
                n_stg.str = STR_BASE + sp[32:16];
                ang  = (i_cfg.mode == MODE_WANDER) ? w_src.heading : w_src.phase;
                // 2nd/3rd quadrant: rotate half a turn, negate at the end
                n_stg.flip = ang[15] ^ ang[14];
                a    = n_stg.flip ? {~ang[15], ang[14:0]} : ang;
                n_stg.cox = CORDIC_X0;
                n_stg.coy = '0;
                n_stg.coz = {{2{a[15]}}, a, 16'd0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stg[k] <= n_stg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_vld};
        end
    end

    assign o_vld  = r_vld[DEPTH-1];
    assign o_item = r_stg[DEPTH-1];

endmodule
`default_nettype wire

// ===== design/pmu_cordic.sv =====
`default_nettype none
module pmu_cordic import pmu_pkg::*; #(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output logic       o_vld,
    output t_item      o_item
);

    localparam int DEPTH = STEPS + 2;

    t_item r_stg [DEPTH];
    logic [DEPTH-1:0] r_vld;

    for (genvar k = 0; k < DEPTH; k++) begin : g_stg
        t_item w_src;
        t_item n_stg;
        if (k == 0) begin : g_first
            assign w_src = i_item;
        end else begin : g_next
            assign w_src = r_stg[k-1];
        end

        if (k < STEPS) begin : g_rot
            always_comb begin
                logic signed [19:0] xs;
                logic signed [19:0] ys;
                logic signed [33:0] at;
                n_stg = w_src;
                xs = w_src.cox >>> k;
                ys = w_src.coy >>> k;
                at = 34'(ATAN_TURNS[k]);
                if (!w_src.coz[33]) begin
                    n_stg.cox = w_src.cox - ys;
                    n_stg.coy = w_src.coy + xs;
                    n_stg.coz = w_src.coz - at;
                end else begin
                    n_stg.cox = w_src.cox + ys;
                    n_stg.coy = w_src.coy - xs;
                    n_stg.coz = w_src.coz + at;
                end
            end
        end else if (k == STEPS) begin : g_mul
            // cos/sin times radius, or times the wander speed
            always_comb begin
                logic signed [19:0] c;
                logic signed [19:0] s;
                logic signed [26:0] m;
                n_stg = w_src;
                c = w_src.flip ? -w_src.cox : w_src.cox;
                s = w_src.flip ? -w_src.coy : w_src.coy;
                m = (i_cfg.mode == MODE_WANDER) ? $signed(WANDER_SPEED)
                                                : $signed({1'b0, w_src.r});
                n_stg.mx = c * m;
                n_stg.my = s * m;
            end
        end else begin : g_place
            always_comb begin
                logic signed [46:0] rx;
                logic signed [46:0] ry;
                logic signed [47:0] plx;
                logic signed [47:0] ply;
                n_stg = w_src;
                rx  = (w_src.mx + 47'sd32768) >>> 16;
                ry  = (w_src.my + 47'sd32768) >>> 16;
                plx = 48'(i_cfg.cx) + 48'(rx) - $signed(48'(i_cfg.sw[23:1]));
                ply = 48'(i_cfg.cy) + 48'(ry) - $signed(48'(i_cfg.sh[23:1]));
                if (w_src.alive && (i_cfg.mode == MODE_ORBIT || i_cfg.mode == MODE_SPIRAL))
                begin
                    n_stg.px = sat24(plx);
                    n_stg.py = sat24(ply);
                end
                if (w_src.alive && i_cfg.mode == MODE_WANDER && w_src.wexp) begin
                    n_stg.vx = rx[23:0];
                    n_stg.vy = ry[23:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stg[k] <= n_stg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_vld};
        end
    end

    assign o_vld  = r_vld[DEPTH-1];
    assign o_item = r_stg[DEPTH-1];

endmodule
`default_nettype wire

// ===== design/pmu_attract.sv =====
`default_nettype none
module pmu_attract import pmu_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output logic       o_vld,
    output t_item      o_item
);

    localparam int DIV_FIRST = SQRT_STEPS + 2;
    localparam int DEPTH     = DIV_FIRST + DIV_STEPS + 1;

    t_item r_stg [DEPTH];
    logic [DEPTH-1:0] r_vld;

    for (genvar k = 0; k < DEPTH; k++) begin : g_stg
        t_item w_src;
        t_item n_stg;
        if (k == 0) begin : g_first
            assign w_src = i_item;
        end else begin : g_next
            assign w_src = r_stg[k-1];
        end

        if (k < SQRT_STEPS) begin : g_sqrt
            // one result bit of floor(sqrt(dx^2 + dy^2)) per pair of radicand bits
            localparam logic [50:0] SBIT = 51'd1 << (50 - 2 * k);
            always_comb begin
                logic [50:0] t;
                n_stg = w_src;
                t = w_src.slen + SBIT;
                if (w_src.srem >= t) begin
                    n_stg.srem = w_src.srem - t;
                    n_stg.slen = (w_src.slen >> 1) + SBIT;
                end else begin
                    n_stg.slen = w_src.slen >> 1;
                end
            end
        end else if (k == SQRT_STEPS) begin : g_mul
            always_comb begin
                n_stg = w_src;
                n_stg.len = w_src.slen[25:0];
                n_stg.nx  = w_src.dx * $signed({1'b0, w_src.str});
                n_stg.ny  = w_src.dy * $signed({1'b0, w_src.str});
            end
        end else if (k == SQRT_STEPS + 1) begin : g_mag
            // magnitude plus half the divisor: round half away from zero
            always_comb begin
                logic [42:0] ax;
                logic [42:0] ay;
                n_stg = w_src;
                ax = w_src.nx[42] ? 43'(-w_src.nx) : 43'(w_src.nx);
                ay = w_src.ny[42] ? 43'(-w_src.ny) : 43'(w_src.ny);
                n_stg.dremx = 44'(ax) + 44'(w_src.len[25:1]);
                n_stg.dremy = 44'(ay) + 44'(w_src.len[25:1]);
                n_stg.qx = '0;
                n_stg.qy = '0;
            end
        end else if (k < DIV_FIRST + DIV_STEPS) begin : g_div
            localparam int DSH = DIV_STEPS - 1 - (k - DIV_FIRST);
            always_comb begin
                logic [43:0] d;
                logic        gx;
                logic        gy;
                n_stg = w_src;
                d  = 44'(w_src.len) << DSH;
                gx = (w_src.dremx >= d);
                gy = (w_src.dremy >= d);
                if (gx) begin
                    n_stg.dremx = w_src.dremx - d;
                end
                if (gy) begin
                    n_stg.dremy = w_src.dremy - d;
                end
                n_stg.qx = {w_src.qx[16:0], gx};
                n_stg.qy = {w_src.qy[16:0], gy};
            end
        end else begin : g_apply
            always_comb begin
                logic signed [23:0] qxs;
                logic signed [23:0] qys;
                n_stg = w_src;
                qxs = $signed({6'd0, w_src.qx});
                qys = $signed({6'd0, w_src.qy});
                if (w_src.alive && i_cfg.mode == MODE_ATTRACT && !w_src.near) begin
                    n_stg.vx = w_src.nx[42] ? -qxs : qxs;
                    n_stg.vy = w_src.ny[42] ? -qys : qys;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stg[k] <= n_stg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_vld};
        end
    end

    assign o_vld  = r_vld[DEPTH-1];
    assign o_item = r_stg[DEPTH-1];

endmodule
`default_nettype wire

// ===== design/pmu_back.sv =====
`default_nettype none
module pmu_back import pmu_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output logic       o_vld,
    output t_item      o_item
);

    t_item r_s0, r_s1;
    t_item n_s0, n_s1;
    logic [1:0] r_vld;

    always_comb begin
        n_s0     = i_item;
        n_s0.mvx = i_item.vx * $signed({1'b0, i_item.dt});
        n_s0.mvy = i_item.vy * $signed({1'b0, i_item.dt});
    end

    // position += speed * dt for the moving patterns
    always_comb begin
        logic               move;
        logic signed [40:0] ix;
        logic signed [40:0] iy;
        n_s1 = r_s0;
        case (i_cfg.mode) inside
            MODE_BURST, MODE_ATTRACT, MODE_RAIN, MODE_WANDER: move = 1'b1;
            default:                                          move = 1'b0;
        endcase
        ix = (r_s0.mvx + 41'sd32768) >>> 16;
        iy = (r_s0.mvy + 41'sd32768) >>> 16;
        if (r_s0.alive && move) begin
            n_s1.px = sat24(48'(r_s0.px) + 48'(ix));
            n_s1.py = sat24(48'(r_s0.py) + 48'(iy));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
        end
    end

    assign o_vld  = r_vld[1];
    assign o_item = r_s1;

endmodule
`default_nettype wire
